>>> rtl/bte_pkg.sv
// Package for the button edge timestamp tracker.
// Holds sizes, codes and the item and result types shared by all rtl files.
// No dependencies.
package bte_pkg;

    localparam int KEY_BUTTONS  = 16;
    localparam int DIR_BUTTONS  = 8;
    localparam int ALL_BUTTONS  = KEY_BUTTONS + DIR_BUTTONS;
    localparam int BTN_IDX_W    = $clog2(ALL_BUTTONS);
    localparam int MASK_BITS    = 24;
    localparam int MASK_BUTTONS = (ALL_BUTTONS < MASK_BITS) ? ALL_BUTTONS : MASK_BITS;
    localparam int TIME_BITS    = 32;

    // Direction buttons follow the key buttons in this order.
    localparam int DIR_S1_UP    = KEY_BUTTONS + 0;
    localparam int DIR_S1_DOWN  = KEY_BUTTONS + 1;
    localparam int DIR_S1_LEFT  = KEY_BUTTONS + 2;
    localparam int DIR_S1_RIGHT = KEY_BUTTONS + 3;
    localparam int DIR_S2_UP    = KEY_BUTTONS + 4;
    localparam int DIR_S2_DOWN  = KEY_BUTTONS + 5;
    localparam int DIR_S2_LEFT  = KEY_BUTTONS + 6;
    localparam int DIR_S2_RIGHT = KEY_BUTTONS + 7;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int THR_W      = 7;
    localparam logic [THR_W-1:0] THR_RESET = 7'd64;
    localparam logic REG_STICK_THRESHOLD = 1'b0;

    // Stream widths.
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 96;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_QUERY  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [23:0]        key_bits;
        logic signed [7:0]  stick1_x;
        logic signed [7:0]  stick1_y;
        logic signed [7:0]  stick2_x;
        logic signed [7:0]  stick2_y;
        logic [31:0]        now_ms;
        logic [4:0]         button_index;
    } t_item;

    typedef struct packed {
        logic [23:0] pressed_mask;
        logic        held;
        logic [31:0] pressed_ms;
        logic [31:0] released_ms;
    } t_result;

endpackage

>>> rtl/button_edge_timestamp_tracker_top.sv
// Top level of the button edge timestamp tracker: stream ports, input and
// result registers, APB configuration. An accepted input word passes the input
// register and then the result register, around the edge and query logic, on its way
// to the master side. Throughput is one word per cycle while the master side takes
// results; a stalled result holds while one more input word is taken.
// Synchronous active-low reset clears flags and times.
module button_edge_timestamp_tracker_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tdata from bit 0: key_bits, stick1_x, stick1_y, stick2_x, stick2_y,
    // now_ms, button_index, zero fill.
    input  logic [bte_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser from bit 0: op.
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata from bit 0: pressed_mask, held flag, pressed_ms, released_ms,
    // zero fill.
    output logic [bte_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bte_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [bte_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [bte_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    bte_pkg::t_item            w_in_item;
    bte_pkg::t_item            r_in_item;
    logic                      r_in_valid;
    bte_pkg::t_result          w_result;
    bte_pkg::t_result          r_out_result;
    logic                      r_out_valid;
    logic                      w_move;
    logic                      w_accept;
    logic [bte_pkg::THR_W-1:0] w_threshold;

    always_comb begin
        w_in_item.op           = bte_pkg::t_op'(s_axis_tuser);
        w_in_item.key_bits     = s_axis_tdata[23:0];
        w_in_item.stick1_x     = s_axis_tdata[31:24];
        w_in_item.stick1_y     = s_axis_tdata[39:32];
        w_in_item.stick2_x     = s_axis_tdata[47:40];
        w_in_item.stick2_y     = s_axis_tdata[55:48];
        w_in_item.now_ms       = s_axis_tdata[87:56];
        w_in_item.button_index = s_axis_tdata[92:88];
    end

    // A word moves to the result register when that register is free or drains.
    assign w_move        = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | w_move;
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item <= w_in_item;
        end
        if (w_move) begin
            r_out_result <= w_result;
        end
    end

    bte_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_threshold (w_threshold)
    );

    bte_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (r_in_item),
        .i_commit    (w_move),
        .i_threshold (w_threshold),
        .o_result    (w_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_result.released_ms, r_out_result.pressed_ms,
                            r_out_result.held, r_out_result.pressed_mask};

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input blocked with an empty input register");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_result)))
        else $error("stalled result lost or changed");

    a_move_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> r_out_valid)
        else $error("word moved but result register not valid");

endmodule

>>> rtl/bte_cfg.sv
// Configuration register block of the button edge timestamp tracker.
// APB-style write and read of the stick threshold; uses bte_pkg.
module bte_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bte_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [bte_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [bte_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [bte_pkg::THR_W-1:0]       o_threshold
);

    logic [bte_pkg::THR_W-1:0] r_threshold;
    logic                      w_reg_idx;
    logic                      w_write;

    // Registers sit on 4-byte boundaries, so the word index starts at bit 2.
    assign w_reg_idx = paddr[2];
    assign w_write   = psel & penable & pwrite & pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= bte_pkg::THR_RESET;
        end else if (w_write && (w_reg_idx == bte_pkg::REG_STICK_THRESHOLD)) begin
            r_threshold <= pwdata[bte_pkg::THR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_reg_idx == bte_pkg::REG_STICK_THRESHOLD) begin
            prdata = bte_pkg::CFG_DATA_W'(r_threshold);
        end
    end

    assign o_threshold = r_threshold;

endmodule

>>> rtl/bte_track.sv
// Button state and timestamp store with the per-item edge and query logic.
// Updates flags and times when an item is committed; uses bte_pkg.
module bte_track (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bte_pkg::t_item            i_item,
    input  logic                      i_commit,
    input  logic [bte_pkg::THR_W-1:0] i_threshold,
    output bte_pkg::t_result          o_result
);

    logic [bte_pkg::ALL_BUTTONS-1:0] r_flags;
    bte_pkg::t_time                  r_press_time   [bte_pkg::ALL_BUTTONS];
    bte_pkg::t_time                  r_release_time [bte_pkg::ALL_BUTTONS];
    bte_pkg::t_time                  r_last_time;

    logic [bte_pkg::ALL_BUTTONS-1:0] w_set;
    logic [bte_pkg::ALL_BUTTONS-1:0] w_clr;
    logic [bte_pkg::ALL_BUTTONS-1:0] w_flags_next;
    logic                            w_is_sample;
    bte_pkg::t_time                  w_now;
    logic [1:0]                      w_s1x, w_s1y, w_s2x, w_s2y;
    logic                            w_in_range;
    logic [bte_pkg::BTN_IDX_W-1:0]   w_qidx;
    logic                            w_qflag;
    bte_pkg::t_time                  w_press_dt;
    bte_pkg::t_time                  w_release_dt;

    // Returns {beyond plus threshold, beyond minus threshold}.
    function automatic logic [1:0] axis_dir(input logic signed [7:0] a,
                                            input logic [bte_pkg::THR_W-1:0] t);
        logic signed [8:0] av;
        logic signed [8:0] tv;
        av = {a[7], a};
        tv = $signed({2'b00, t});
        return {av > tv, av < -tv};
    endfunction

    assign w_is_sample = (i_item.op == bte_pkg::OP_SAMPLE);
    assign w_now       = bte_pkg::t_time'(i_item.now_ms);
    assign w_s1x       = axis_dir(i_item.stick1_x, i_threshold);
    assign w_s1y       = axis_dir(i_item.stick1_y, i_threshold);
    assign w_s2x       = axis_dir(i_item.stick2_x, i_threshold);
    assign w_s2y       = axis_dir(i_item.stick2_y, i_threshold);

    always_comb begin
        w_set = '0;
        w_clr = '0;
        for (int i = 0; i < bte_pkg::KEY_BUTTONS; i++) begin
            w_set[i] = i_item.key_bits[i] & ~r_flags[i];
            w_clr[i] = ~i_item.key_bits[i] & r_flags[i];
        end
        // A direction presses beyond its side; only the centre band releases.
        w_set[bte_pkg::DIR_S1_RIGHT] = w_s1x[1] & ~r_flags[bte_pkg::DIR_S1_RIGHT];
        w_set[bte_pkg::DIR_S1_LEFT]  = w_s1x[0] & ~r_flags[bte_pkg::DIR_S1_LEFT];
        w_clr[bte_pkg::DIR_S1_RIGHT] = ~|w_s1x & r_flags[bte_pkg::DIR_S1_RIGHT];
        w_clr[bte_pkg::DIR_S1_LEFT]  = ~|w_s1x & r_flags[bte_pkg::DIR_S1_LEFT];
        w_set[bte_pkg::DIR_S1_DOWN]  = w_s1y[1] & ~r_flags[bte_pkg::DIR_S1_DOWN];
        w_set[bte_pkg::DIR_S1_UP]    = w_s1y[0] & ~r_flags[bte_pkg::DIR_S1_UP];
        w_clr[bte_pkg::DIR_S1_DOWN]  = ~|w_s1y & r_flags[bte_pkg::DIR_S1_DOWN];
        w_clr[bte_pkg::DIR_S1_UP]    = ~|w_s1y & r_flags[bte_pkg::DIR_S1_UP];
        w_set[bte_pkg::DIR_S2_RIGHT] = w_s2x[1] & ~r_flags[bte_pkg::DIR_S2_RIGHT];
        w_set[bte_pkg::DIR_S2_LEFT]  = w_s2x[0] & ~r_flags[bte_pkg::DIR_S2_LEFT];
        w_clr[bte_pkg::DIR_S2_RIGHT] = ~|w_s2x & r_flags[bte_pkg::DIR_S2_RIGHT];
        w_clr[bte_pkg::DIR_S2_LEFT]  = ~|w_s2x & r_flags[bte_pkg::DIR_S2_LEFT];
        w_set[bte_pkg::DIR_S2_DOWN]  = w_s2y[1] & ~r_flags[bte_pkg::DIR_S2_DOWN];
        w_set[bte_pkg::DIR_S2_UP]    = w_s2y[0] & ~r_flags[bte_pkg::DIR_S2_UP];
        w_clr[bte_pkg::DIR_S2_DOWN]  = ~|w_s2y & r_flags[bte_pkg::DIR_S2_DOWN];
        w_clr[bte_pkg::DIR_S2_UP]    = ~|w_s2y & r_flags[bte_pkg::DIR_S2_UP];
        if (!w_is_sample) begin
            w_set = '0;
            w_clr = '0;
        end
    end

    assign w_flags_next = (r_flags | w_set) & ~w_clr;

    // Queries see the state left by earlier items.
    assign w_in_range   = (int'(i_item.button_index) < bte_pkg::ALL_BUTTONS);
    assign w_qidx       = i_item.button_index[bte_pkg::BTN_IDX_W-1:0];
    assign w_qflag      = w_in_range & r_flags[w_qidx];
    assign w_press_dt   = r_last_time - r_press_time[w_qidx];
    assign w_release_dt = r_last_time - r_release_time[w_qidx];

    always_comb begin
        o_result = '0;
        o_result.pressed_mask = bte_pkg::MASK_BITS'(w_flags_next[bte_pkg::MASK_BUTTONS-1:0]);
        if (!w_is_sample && w_in_range) begin
            o_result.held = w_qflag;
            if (w_qflag) begin
                o_result.pressed_ms = 32'(w_press_dt);
            end else begin
                o_result.released_ms = 32'(w_release_dt);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_last_time <= '0;
            for (int i = 0; i < bte_pkg::ALL_BUTTONS; i++) begin
                r_press_time[i]   <= '0;
                r_release_time[i] <= '0;
            end
        end else if (i_commit && w_is_sample) begin
            r_flags     <= w_flags_next;
            r_last_time <= w_now;
            for (int i = 0; i < bte_pkg::ALL_BUTTONS; i++) begin
                if (w_set[i]) begin
                    r_press_time[i] <= w_now;
                end
                if (w_clr[i]) begin
                    r_release_time[i] <= w_now;
                end
            end
        end
    end

    a_key0_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && w_is_sample) |=> (r_flags[0] == $past(i_item.key_bits[0])))
        else $error("key button 0 flag does not follow its key bit");

    a_query_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && !w_is_sample) |=> ($stable(r_flags) && $stable(r_last_time)))
        else $error("a query changed the button state");

    a_one_time_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_result.held |-> (o_result.pressed_ms == '0))
        else $error("press time reported for a released button");

    a_sample_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_is_sample |-> (!o_result.held && o_result.released_ms == '0))
        else $error("sample result carries query fields");

endmodule

>>> tb/button_edge_timestamp_tracker_checker.sv
// Checker for the button edge timestamp tracker: watches both stream channels and the APB port,
// predicts every result word and compares it field by field with what the block returns.
// Depends on bte_pkg for the item and result types, the button numbering and the widths.
module button_edge_timestamp_tracker_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [bte_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                           i_s_axis_tuser,
    input  logic                           i_s_axis_tvalid,
    input  logic                           i_s_axis_tready,
    input  logic [bte_pkg::OUT_DATA_W-1:0] i_m_axis_tdata,
    input  logic                           i_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [bte_pkg::CFG_ADDR_W-1:0] i_paddr,
    input  logic [bte_pkg::CFG_DATA_W-1:0] i_pwdata,
    input  logic [bte_pkg::CFG_DATA_W-1:0] i_prdata,
    input  logic                           i_pready,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import bte_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] THR_ADDR = {REG_STICK_THRESHOLD, 2'b00};

    logic [THR_W-1:0] thr_level;
    logic             btn_down [ALL_BUTTONS];
    t_time            press_at [ALL_BUTTONS];
    t_time            release_at [ALL_BUTTONS];
    t_time            last_sample_t;
    t_result          awaited_results [$];

    function automatic void mark_press(int b);
        if (!btn_down[b]) begin
            btn_down[b] = 1'b1;
            press_at[b] = last_sample_t;
        end
    endfunction

    function automatic void mark_release(int b);
        if (btn_down[b]) begin
            btn_down[b]   = 1'b0;
            release_at[b] = last_sample_t;
        end
    endfunction

    // Only the centre band releases; a swing straight across keeps the old side pressed.
    function automatic void track_axis(logic signed [7:0] axis, int pos_b, int neg_b);
        int a;
        int t;
        a = axis;
        t = thr_level;
        if (a > t) begin
            mark_press(pos_b);
        end else if (a < -t) begin
            mark_press(neg_b);
        end else begin
            mark_release(pos_b);
            mark_release(neg_b);
        end
    endfunction

    function automatic t_result predict_button_word(t_item it);
        t_result r;
        int      b;
        int      i;
        t_time   span;
        r = '0;
        if (it.op == OP_SAMPLE) begin
            last_sample_t = t_time'(it.now_ms);
            for (i = 0; i < KEY_BUTTONS; i++) begin
                if (it.key_bits[i]) begin
                    mark_press(i);
                end else begin
                    mark_release(i);
                end
            end
            track_axis(it.stick1_x, DIR_S1_RIGHT, DIR_S1_LEFT);
            track_axis(it.stick1_y, DIR_S1_DOWN, DIR_S1_UP);
            track_axis(it.stick2_x, DIR_S2_RIGHT, DIR_S2_LEFT);
            track_axis(it.stick2_y, DIR_S2_DOWN, DIR_S2_UP);
        end else begin
            b = it.button_index;
            if (b < ALL_BUTTONS) begin
                if (btn_down[b]) begin
                    span         = last_sample_t - press_at[b];
                    r.held       = 1'b1;
                    r.pressed_ms = span[31:0];
                end else begin
                    span          = last_sample_t - release_at[b];
                    r.released_ms = span[31:0];
                end
            end
        end
        for (i = 0; i < MASK_BUTTONS; i++) begin
            r.pressed_mask[i] = btn_down[i];
        end
        return r;
    endfunction

    function automatic t_item unpack_word(logic [IN_DATA_W-1:0] w, logic kind);
        t_item it;
        it.op           = t_op'(kind);
        it.key_bits     = w[23:0];
        it.stick1_x     = w[31:24];
        it.stick1_y     = w[39:32];
        it.stick2_x     = w[47:40];
        it.stick2_y     = w[55:48];
        it.now_ms       = w[87:56];
        it.button_index = w[92:88];
        return it;
    endfunction

    function automatic int field_differs(string label, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch in result %0d, expected %h, actual %h",
                     $time, label, o_checked, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_level     = THR_RESET;
            last_sample_t = '0;
            for (int i = 0; i < ALL_BUTTONS; i++) begin
                btn_down[i]   = 1'b0;
                press_at[i]   = '0;
                release_at[i] = '0;
            end
            awaited_results.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == THR_ADDR) begin
                if (i_pwrite) begin
                    thr_level = i_pwdata[THR_W-1:0];
                end else begin
                    o_fail_count += field_differs("threshold readback", 32'(thr_level),
                                                  i_prdata);
                end
            end

            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, i_m_axis_tdata);
                    o_fail_count++;
                end else begin
                    t_result want;
                    want = awaited_results.pop_front();
                    o_fail_count += field_differs("pressed_mask", 32'(want.pressed_mask),
                                                  32'(i_m_axis_tdata[23:0]));
                    o_fail_count += field_differs("held flag", 32'(want.held),
                                                  32'(i_m_axis_tdata[24]));
                    o_fail_count += field_differs("pressed_ms", want.pressed_ms,
                                                  i_m_axis_tdata[56:25]);
                    o_fail_count += field_differs("released_ms", want.released_ms,
                                                  i_m_axis_tdata[88:57]);
                    o_fail_count += field_differs("zero fill", 32'd0,
                                                  32'(i_m_axis_tdata[OUT_DATA_W-1:89]));
                end
                o_checked++;
            end

            if (i_s_axis_tvalid && i_s_axis_tready) begin
                awaited_results.push_back(
                    predict_button_word(unpack_word(i_s_axis_tdata, i_s_axis_tuser)));
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

>>> tb/tb_button_edge_timestamp_tracker_top.sv
// Testbench top for the button edge timestamp tracker: clock, reset, directed and random words,
// APB threshold settings, random idling on both streams and the final verdict.
// Depends on bte_pkg, the block's top level and button_edge_timestamp_tracker_checker.
module tb_button_edge_timestamp_tracker_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bte_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RX_HOLD       = 200;
    localparam int PHASE_WORDS   = 200;
    localparam int DRAIN_CYCLES  = 8;
    localparam logic [CFG_ADDR_W-1:0] THR_ADDR = {REG_STICK_THRESHOLD, 2'b00};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int checked;
    int cycle_count;
    int words_sent;
    int thr_settings;
    int cur_thr;
    bit burst_mode;
    bit rx_hold_req;
    logic [23:0] key_state;
    logic [31:0] sim_ms;

    button_edge_timestamp_tracker_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    button_edge_timestamp_tracker_checker checker_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tdata(s_axis_tdata), .i_s_axis_tuser(s_axis_tuser),
        .i_s_axis_tvalid(s_axis_tvalid), .i_s_axis_tready(s_axis_tready),
        .i_m_axis_tdata(m_axis_tdata), .i_m_axis_tvalid(m_axis_tvalid),
        .i_m_axis_tready(m_axis_tready),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_prdata(prdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d results still awaited", $time, pending);
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: random ready gaps, plus one long hold-off on request.
    initial begin : result_sink
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD) @(negedge i_clk);
            end
            gap = burst_mode ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_word(t_item it);
        logic [IN_DATA_W-1:0] w;
        w          = '0;
        w[23:0]    = it.key_bits;
        w[31:24]   = it.stick1_x;
        w[39:32]   = it.stick1_y;
        w[47:40]   = it.stick2_x;
        w[55:48]   = it.stick2_y;
        w[87:56]   = it.now_ms;
        w[92:88]   = it.button_index;
        return w;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance with valid still up.
    task automatic offer_word(input t_item it);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= pack_word(it);
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic cfg_access(input bit wr, input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= THR_ADDR;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_threshold(input int thr);
        logic [CFG_DATA_W-1:0] v;
        v = $urandom;
        v[THR_W-1:0] = thr[THR_W-1:0];
        cfg_access(1'b1, v);
        cfg_access(1'b0, '0);
        cur_thr = thr;
        thr_settings++;
    endtask

    function automatic t_item sample_item(logic [23:0] keys, logic signed [7:0] s1x,
                                          logic signed [7:0] s1y, logic signed [7:0] s2x,
                                          logic signed [7:0] s2y, logic [31:0] t);
        t_item it;
        it.op           = OP_SAMPLE;
        it.key_bits     = keys;
        it.stick1_x     = s1x;
        it.stick1_y     = s1y;
        it.stick2_x     = s2x;
        it.stick2_y     = s2y;
        it.now_ms       = t;
        it.button_index = 5'($urandom);
        return it;
    endfunction

    // Fields other than the index are noise on a query.
    function automatic t_item query_item(int idx);
        t_item it;
        it              = sample_item(24'($urandom), 8'($urandom), 8'($urandom),
                                      8'($urandom), 8'($urandom), $urandom);
        it.op           = OP_QUERY;
        it.button_index = 5'(idx);
        return it;
    endfunction

    // Axis values cluster around the threshold edges, the centre band and the extremes.
    function automatic logic [7:0] pick_axis(int thr);
        int v;
        case ($urandom_range(0, 6))
            0: v = int'($urandom_range(0, 2 * thr)) - thr;
            1: v = (thr < 127) ? int'($urandom_range(thr + 1, 127)) : 127;
            2: v = -int'($urandom_range(thr + 1, 128));
            3: v = thr;
            4: v = -thr;
            5: v = $urandom_range(0, 1) ? ((thr < 127) ? thr + 1 : 127) : -(thr + 1);
            default: v = int'($urandom_range(0, 255)) - 128;
        endcase
        return v[7:0];
    endfunction

    function automatic t_item random_item(int thr);
        t_item it;
        if ($urandom_range(0, 99) < 55) begin
            case ($urandom_range(0, 9))
                0: key_state = 24'($urandom);
                1: key_state = '0;
                2: ;
                default: key_state ^= 24'(1) << $urandom_range(0, 23);
            endcase
            if ($urandom_range(0, 29) == 0) begin
                sim_ms = $urandom;
            end else begin
                sim_ms += $urandom_range(0, 50);
            end
            it = sample_item(key_state, pick_axis(thr), pick_axis(thr), pick_axis(thr),
                             pick_axis(thr), sim_ms);
        end else begin
            it = query_item(($urandom_range(0, 99) < 85) ? $urandom_range(0, ALL_BUTTONS - 1)
                                                        : $urandom_range(ALL_BUTTONS, 31));
        end
        return it;
    endfunction

    initial begin : stimulus
        int thr_plan [6];
        i_rst_n       = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tvalid = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        burst_mode    = 1'b0;
        rx_hold_req   = 1'b0;
        words_sent    = 0;
        thr_settings  = 0;
        cur_thr       = THR_RESET;
        key_state     = '0;
        sim_ms        = 32'd2000;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset value of the threshold reads back first.
        cfg_access(1'b0, '0);

        // Queries before any sample measure against time zero.
        offer_word(query_item(0));
        offer_word(query_item(DIR_S2_RIGHT));
        offer_word(query_item(31));
        offer_word(sample_item(24'hFFFFFF, 8'sd127, -8'sd128, 8'sd127, -8'sd128, 32'd1000));
        offer_word(query_item(KEY_BUTTONS - 1));
        offer_word(query_item(DIR_S1_UP));
        offer_word(query_item(DIR_S1_RIGHT));
        offer_word(sample_item(24'h000000, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 32'd1500));
        offer_word(sample_item(24'h000000, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 32'd1600));
        offer_word(query_item(0));
        // Swing straight from right to left: both directions end up pressed.
        offer_word(sample_item(24'h000000, 8'sd127, 8'sd0, 8'sd0, 8'sd0, 32'd1700));
        offer_word(sample_item(24'h000000, -8'sd128, 8'sd0, 8'sd0, 8'sd0, 32'd1800));
        offer_word(query_item(DIR_S1_RIGHT));
        offer_word(query_item(DIR_S1_LEFT));
        // Exactly at the threshold stays released, one beyond it presses.
        offer_word(sample_item(24'h000000, 8'sd64, -8'sd64, 8'sd65, -8'sd65, 32'd1900));
        offer_word(query_item(DIR_S2_UP));
        // Key bits above the key buttons do nothing; time at its top value.
        offer_word(sample_item(24'hFF0000, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 32'hFFFF_FFFF));
        offer_word(query_item(DIR_S2_RIGHT));
        offer_word(sample_item(24'h00FFFF, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 32'd5));
        offer_word(sample_item(24'h00FFFF, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 32'h10));
        offer_word(query_item(3));
        // Elapsed time across the wrap of the millisecond counter.
        offer_word(query_item(DIR_S2_RIGHT));
        offer_word(query_item(ALL_BUTTONS));

        thr_plan = '{0, 127, 1, 126, $urandom_range(2, 125), THR_RESET};
        foreach (thr_plan[p]) begin
            drain_results();
            set_threshold(thr_plan[p]);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(0, 49) == 0) begin
                    burst_mode = !burst_mode;
                end
                if (p == 1 && n == 50) begin
                    // Long result stall while words keep coming back to back.
                    rx_hold_req = 1'b1;
                    burst_mode  = 1'b1;
                end
                if (p == 1 && n == 90) begin
                    burst_mode = 1'b0;
                end
                if (p == 2 && n == 100) begin
                    drain_results();
                end
                offer_word(random_item(cur_thr));
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Run covered %0d words with %0d results checked over %0d threshold settings,",
                 words_sent, checked, thr_settings);
        $display("including a %0d cycle result stall and a full drain mid-phase.", RX_HOLD);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
